// ===== design/gct_pkg.sv =====
// Shared types and constants of the greedy centroid tracker.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none
package gct_pkg;

    localparam int POS_W     = 16;
    localparam int ID_W      = 8;
    localparam int MISS_W    = 8;
    localparam int NUM_IDS   = 256;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_RADIUS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MISSED   = 8'd1;

    localparam logic [POS_W-1:0]  RADIUS_RESET = 16'd800;
    localparam logic [MISS_W-1:0] MISSED_RESET = 8'd10;
    localparam logic [MISS_W-1:0] MISS_SAT     = 8'hFF;
    localparam logic [ID_W-1:0]   ID_LAST      = 8'hFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_M_ID,
        ST_M_TRK,
        ST_M_DRD,
        ST_M_DIF,
        ST_M_SQ,
        ST_M_CMP,
        ST_M_DEC,
        ST_N_CHK,
        ST_N_RD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic det_wr;
        logic v_inc;
        logic i_clr;
        logic i_inc;
        logic trk_load;
        logic dif;
        logic sq;
        logic cmp;
        logic match_emit;
        logic miss_upd;
        logic new_emit;
        logic frame_clr;
    } t_cmd;

    typedef struct packed {
        logic v_live;
        logic v_last;
        logic i_end;
        logic i_used;
        logic hit;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

// ===== design/gct_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module gct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== design/gct_ctrl.sv =====
// Frame sequencer of the centroid tracker: match walk, then new-track walk.
// Depends on gct_pkg.
`default_nettype none
module gct_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_mode,
    input  gct_pkg::t_stat      i_stat,
    output logic                o_in_ready,
    output gct_pkg::t_cmd       o_cmd
);
    import gct_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (!i_mode) begin
                        o_cmd.det_wr = 1'b1;
                    end else begin
                        n_state = ST_M_ID;
                    end
                end
            end
            ST_M_ID: begin
                if (i_stat.v_live) begin
                    n_state = ST_M_TRK;
                end else begin
                    o_cmd.v_inc = 1'b1;
                    if (i_stat.v_last) begin
                        o_cmd.i_clr = 1'b1;
                        n_state     = ST_N_CHK;
                    end
                end
            end
            ST_M_TRK: begin
                o_cmd.trk_load = 1'b1;
                n_state        = ST_M_DRD;
            end
            ST_M_DRD: begin
                if (i_stat.i_end) begin
                    n_state = ST_M_DEC;
                end else if (i_stat.i_used) begin
                    o_cmd.i_inc = 1'b1;
                end else begin
                    n_state = ST_M_DIF;
                end
            end
            ST_M_DIF: begin
                o_cmd.dif = 1'b1;
                n_state   = ST_M_SQ;
            end
            ST_M_SQ: begin
                o_cmd.sq = 1'b1;
                n_state  = ST_M_CMP;
            end
            ST_M_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = ST_M_DRD;
            end
            ST_M_DEC: begin
                // hold on a match until the output register frees up
                if (!i_stat.hit || i_stat.out_free) begin
                    o_cmd.match_emit = i_stat.hit;
                    o_cmd.miss_upd   = !i_stat.hit;
                    o_cmd.v_inc      = 1'b1;
                    if (i_stat.v_last) begin
                        o_cmd.i_clr = 1'b1;
                        n_state     = ST_N_CHK;
                    end else begin
                        n_state = ST_M_ID;
                    end
                end
            end
            ST_N_CHK: begin
                if (i_stat.i_end) begin
                    n_state = ST_DONE;
                end else if (i_stat.i_used) begin
                    o_cmd.i_inc = 1'b1;
                end else begin
                    n_state = ST_N_RD;
                end
            end
            ST_N_RD: begin
                if (i_stat.out_free) begin
                    o_cmd.new_emit = 1'b1;
                    o_cmd.i_inc    = 1'b1;
                    n_state        = ST_N_CHK;
                end
            end
            ST_DONE: begin
                o_cmd.frame_clr = 1'b1;
                n_state         = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== design/gct_dp.sv =====
// Datapath of the centroid tracker: center buffer, id-indexed track table,
// distance unit, best-match registers, config registers and output register.
// Depends on gct_pkg and gct_ram.
`default_nettype none
module gct_dp #(
    parameter int MAX_TRACKS     = 32,
    parameter int MAX_DETECTIONS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  gct_pkg::t_cmd                          i_cmd,
    output gct_pkg::t_stat                         o_stat,
    input  wire logic [gct_pkg::POS_W-1:0]         i_x_pos,
    input  wire logic [gct_pkg::POS_W-1:0]         i_y_pos,
    input  wire logic                              i_cfg_valid,
    input  wire logic [gct_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [gct_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    input  wire logic                              i_out_ready,
    output logic                                   o_out_valid,
    output logic      [gct_pkg::ID_W-1:0]          o_track_id,
    output logic      [gct_pkg::POS_W-1:0]         o_out_x,
    output logic      [gct_pkg::POS_W-1:0]         o_out_y,
    output logic                                   o_is_new,
    output logic                                   o_stored,
    output logic                                   o_last
);
    import gct_pkg::*;

    localparam int DCW = $clog2(MAX_DETECTIONS + 1);
    localparam int DAW = (MAX_DETECTIONS > 1) ? $clog2(MAX_DETECTIONS) : 1;
    localparam int TCW = $clog2(MAX_TRACKS + 1);
    localparam int TRW = 2 * POS_W + MISS_W;
    localparam int SQW = 2 * POS_W;

    // configuration
    logic [POS_W-1:0]  r_radius;
    logic [MISS_W-1:0] r_max_missed;
    logic [SQW-1:0]    r_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius     <= RADIUS_RESET;
            r_max_missed <= MISSED_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_MATCH_RADIUS) begin
                r_radius <= i_cfg_data;
            end else if (i_cfg_index == CFG_MAX_MISSED) begin
                r_max_missed <= i_cfg_data[MISS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lim <= r_radius * r_radius;
    end

    // control counters and flags
    logic [DCW-1:0]            r_det_cnt;
    logic [DCW-1:0]            r_i;
    logic [DCW-1:0]            r_n;
    logic [ID_W-1:0]           r_v;
    logic [ID_W-1:0]           r_idc;
    logic [TCW-1:0]            r_ntrk;
    logic [NUM_IDS-1:0]        r_tvalid;
    logic [MAX_DETECTIONS-1:0] r_det_used;
    logic                      r_found;
    logic                      r_out_valid;

    // payload registers
    logic [POS_W-1:0]  r_tx, r_ty, r_cx, r_cy, r_dx, r_dy, r_bx, r_by;
    logic [MISS_W-1:0] r_tm;
    logic [SQW-1:0]    r_dx2, r_dy2;
    logic [SQW:0]      r_bd;
    logic [DAW-1:0]    r_best;

    logic [2*POS_W-1:0] det_rdata;
    logic [TRW-1:0]     trk_rdata;
    logic               det_full;
    logic               det_we;
    logic               out_free;
    logic [SQW:0]       sq_sum;
    logic [MISS_W-1:0]  miss_next;
    logic               drop;
    logic               id_live;
    logic               room;
    logic               new_stored;
    logic               trk_we;
    logic [ID_W-1:0]    trk_waddr;
    logic [TRW-1:0]     trk_wdata;
    logic [POS_W-1:0]   det_x, det_y;
    logic               is_last;

    assign det_full   = (r_det_cnt == DCW'(MAX_DETECTIONS));
    assign det_we     = i_cmd.det_wr && !det_full;
    assign out_free   = !r_out_valid || i_out_ready;
    assign det_x      = det_rdata[2*POS_W-1:POS_W];
    assign det_y      = det_rdata[POS_W-1:0];
    assign sq_sum     = {1'b0, r_dx2} + {1'b0, r_dy2};
    assign miss_next  = (r_tm == MISS_SAT) ? MISS_SAT : r_tm + 1'b1;
    assign drop       = miss_next > r_max_missed;
    assign id_live    = r_tvalid[r_idc];
    assign room       = r_ntrk < TCW'(MAX_TRACKS);
    assign new_stored = id_live || room;
    assign is_last    = (r_n + 1'b1) == r_det_cnt;

    // track table write: matched move, miss aging, or new track
    always_comb begin
        trk_we    = 1'b0;
        trk_waddr = r_v;
        trk_wdata = {r_bx, r_by, MISS_W'(0)};
        if (i_cmd.match_emit) begin
            trk_we = 1'b1;
        end else if (i_cmd.miss_upd) begin
            trk_we    = !drop;
            trk_wdata = {r_tx, r_ty, miss_next};
        end else if (i_cmd.new_emit) begin
            trk_we    = new_stored;
            trk_waddr = r_idc;
            trk_wdata = {det_x, det_y, MISS_W'(0)};
        end
    end

    gct_ram #(
        .WIDTH (2 * POS_W),
        .DEPTH (MAX_DETECTIONS)
    ) u_det_ram (
        .i_clk   (i_clk),
        .i_we    (det_we),
        .i_waddr (r_det_cnt[DAW-1:0]),
        .i_wdata ({i_x_pos, i_y_pos}),
        .i_raddr (r_i[DAW-1:0]),
        .o_rdata (det_rdata)
    );

    gct_ram #(
        .WIDTH (TRW),
        .DEPTH (NUM_IDS)
    ) u_trk_ram (
        .i_clk   (i_clk),
        .i_we    (trk_we),
        .i_waddr (trk_waddr),
        .i_wdata (trk_wdata),
        .i_raddr (r_v),
        .o_rdata (trk_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_det_cnt   <= '0;
            r_i         <= '0;
            r_n         <= '0;
            r_v         <= '0;
            r_idc       <= '0;
            r_ntrk      <= '0;
            r_tvalid    <= '0;
            r_det_used  <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (det_we) begin
                r_det_cnt <= r_det_cnt + 1'b1;
            end
            if (i_cmd.i_clr || i_cmd.trk_load) begin
                r_i <= '0;
            end else if (i_cmd.i_inc || i_cmd.cmp) begin
                r_i <= r_i + 1'b1;
            end
            if (i_cmd.v_inc) begin
                r_v <= r_v + 1'b1;
            end
            if (i_cmd.trk_load) begin
                r_found <= 1'b0;
            end else if (i_cmd.cmp && (!r_found || sq_sum < r_bd)) begin
                r_found <= 1'b1;
            end
            if (i_cmd.match_emit) begin
                r_det_used[r_best] <= 1'b1;
            end
            if (i_cmd.miss_upd && drop) begin
                r_tvalid[r_v] <= 1'b0;
                r_ntrk        <= r_ntrk - 1'b1;
            end
            if (i_cmd.new_emit) begin
                r_idc <= r_idc + 1'b1;
                if (!id_live && room) begin
                    r_tvalid[r_idc] <= 1'b1;
                    r_ntrk          <= r_ntrk + 1'b1;
                end
            end
            if (i_cmd.match_emit || i_cmd.new_emit) begin
                r_n         <= r_n + 1'b1;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.frame_clr) begin
                r_det_cnt  <= '0;
                r_n        <= '0;
                r_det_used <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.trk_load) begin
            r_tx <= trk_rdata[TRW-1:POS_W+MISS_W];
            r_ty <= trk_rdata[POS_W+MISS_W-1:MISS_W];
            r_tm <= trk_rdata[MISS_W-1:0];
        end
        if (i_cmd.dif) begin
            r_cx <= det_x;
            r_cy <= det_y;
            r_dx <= (det_x > r_tx) ? det_x - r_tx : r_tx - det_x;
            r_dy <= (det_y > r_ty) ? det_y - r_ty : r_ty - det_y;
        end
        if (i_cmd.sq) begin
            r_dx2 <= r_dx * r_dx;
            r_dy2 <= r_dy * r_dy;
        end
        if (i_cmd.cmp && (!r_found || sq_sum < r_bd)) begin
            r_bd   <= sq_sum;
            r_best <= r_i[DAW-1:0];
            r_bx   <= r_cx;
            r_by   <= r_cy;
        end
        if (i_cmd.match_emit) begin
            o_track_id <= r_v;
            o_out_x    <= r_bx;
            o_out_y    <= r_by;
            o_is_new   <= 1'b0;
            o_stored   <= 1'b1;
            o_last     <= is_last;
        end else if (i_cmd.new_emit) begin
            o_track_id <= r_idc;
            o_out_x    <= det_x;
            o_out_y    <= det_y;
            o_is_new   <= 1'b1;
            o_stored   <= new_stored;
            o_last     <= is_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_stat.v_live   = r_tvalid[r_v];
    assign o_stat.v_last   = (r_v == ID_LAST);
    assign o_stat.i_end    = (r_i == r_det_cnt);
    assign o_stat.i_used   = r_det_used[r_i[DAW-1:0]];
    assign o_stat.hit      = r_found && (r_bd < {1'b0, r_lim});
    assign o_stat.out_free = out_free;
endmodule
`default_nettype wire

// ===== design/greedy_centroid_tracker_core.sv =====
// Top level of the greedy nearest-neighbor centroid tracker.
// Depends on gct_pkg, gct_ctrl, gct_dp (and through it gct_ram).
//
// Usage:
//  - Input channel (i_in_valid/o_in_ready): send one transfer per marker center
//    with i_mode low, then one transfer with i_mode high to close the frame.
//    Centers beyond MAX_DETECTIONS in a frame are dropped.
//  - Output channel (o_out_valid/i_out_ready): an end of frame yields one result
//    per buffered center: matched tracks first in ascending id, then new tracks
//    in arrival order; o_last marks the final one. An empty frame yields none.
//  - Config channel (i_cfg_valid/o_cfg_ready, always ready): index 0 writes
//    match_radius, index 1 max_missed; write only while the block is idle.
//  - Frame walk: an end of frame keeps the input closed while the block walks the
//    whole id space; each live track is compared with every unused center by the
//    read / abs / square / compare sequence of the single distance unit, then the
//    unmatched centers are emitted as new tracks and the frame is closed.
//  - Reset clears the track table, the center buffer and the id counter and
//    restores match_radius 800 and max_missed 10.
//  - A stalled receiver holds the walk at the next result; nothing is lost.
`default_nettype none
module greedy_centroid_tracker_core #(
    parameter int MAX_TRACKS     = 32,
    parameter int MAX_DETECTIONS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic                              i_mode,
    input  wire logic [gct_pkg::POS_W-1:0]         i_x_pos,
    input  wire logic [gct_pkg::POS_W-1:0]         i_y_pos,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [gct_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [gct_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic      [gct_pkg::ID_W-1:0]          o_track_id,
    output logic      [gct_pkg::POS_W-1:0]         o_out_x,
    output logic      [gct_pkg::POS_W-1:0]         o_out_y,
    output logic                                   o_is_new,
    output logic                                   o_stored,
    output logic                                   o_last
);
    import gct_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // config writes are always accepted and registered directly
    assign o_cfg_ready = 1'b1;

    // sequence the frame walk
    gct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // hold tables, distance unit and the output register
    gct_dp #(
        .MAX_TRACKS     (MAX_TRACKS),
        .MAX_DETECTIONS (MAX_DETECTIONS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_x_pos     (i_x_pos),
        .i_y_pos     (i_y_pos),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_track_id  (o_track_id),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_is_new    (o_is_new),
        .o_stored    (o_stored),
        .o_last      (o_last)
    );

    // an end-of-frame transfer starts the walk and closes the input
    a_eof_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_mode) |=> !o_in_ready)
        else $error("input still ready after end of frame");

    // only a new center can miss the table
    a_unstored_is_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_stored) |-> o_is_new)
        else $error("matched result flagged as not stored");

    // nothing follows the last result of a frame without a new end of frame
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last) |=> !o_out_valid)
        else $error("result after last of frame");
endmodule
`default_nettype wire
